@@ rtl/core/tsd_pkg.sv @@
// Shared widths, constants and pipeline beat types for the tetrahedron
// shape-derivative core. No dependencies.
`timescale 1ns / 1ps

package tsd_pkg;

  localparam int COORD_W    = 32;
  localparam int FRAC_BITS  = 16;
  localparam int DIFF_W     = COORD_W + 1;
  localparam int PROD_W     = 2 * DIFF_W;
  localparam int ADJ_W      = PROD_W + 1;
  localparam int SUM_W      = ADJ_W + 2;
  localparam int ADJ_LO_W   = 34;
  localparam int ADJ_HI_W   = ADJ_W - ADJ_LO_W;
  localparam int PL_W       = DIFF_W + ADJ_LO_W + 1;
  localparam int PH_W       = DIFF_W + ADJ_HI_W;
  localparam int DET_W      = 101;
  localparam int MAG_W      = DET_W - 1;
  localparam int DER_W      = 2 * FRAC_BITS;
  localparam int DIV_STEPS  = DER_W + 1;
  localparam int VOL_W      = 63;
  localparam int VOL_NUM_W  = 2 * DIV_STEPS;
  localparam int VOL_SHIFT  = 3 * FRAC_BITS - 32 + 1;

  localparam logic [MAG_W:0] VOL_BIAS  = (MAG_W + 1)'(3) << (3 * FRAC_BITS - 32);
  localparam logic [MAG_W:0] VOL_SAT_Y = (MAG_W + 1)'(3) << VOL_W;
  localparam logic [DER_W-1:0] DER_MAX = {1'b0, {(DER_W - 1){1'b1}}};
  localparam logic [DER_W-1:0] DER_MIN = {1'b1, {(DER_W - 1){1'b0}}};
  localparam logic [VOL_W-1:0] VOL_MAX = '1;
  localparam logic [1:0] LAST_NODE = 2'd3;

  typedef struct packed {
    logic [MAG_W-1:0]     rem;
    logic [DIV_STEPS-1:0] quo;
    logic                 neg;
    logic                 ovf;
  } lane_t;

  typedef struct packed {
    logic [MAG_W-1:0]     dmag;
    logic                 sing;
    logic [1:0]           node;
    logic                 last;
    logic [VOL_NUM_W-1:0] vw;
    logic [1:0]           vr;
    logic                 vsat;
  } beat_t;

endpackage

@@ rtl/core/tetra_shape_derivatives.sv @@
// Tetrahedron shape-function derivative pipeline: Jacobian, adjugate,
// determinant, per-node restoring division and volume. Uses tsd_pkg.
// Nodes 0 to 3 of an element leave in order on the single result channel.
// Throughput: one result beat per cycle while out_stall_i is low; the node
// serializer takes a new element only once the previous one's last node is
// issued. Reset clears the valid bits and the node counter only; payload
// registers are not reset.
`timescale 1ns / 1ps

module tetra_shape_derivatives import tsd_pkg::*; (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      in_valid_i,
  output logic                      in_stall_o,
  input  logic signed [COORD_W-1:0] v0_x_i,
  input  logic signed [COORD_W-1:0] v0_y_i,
  input  logic signed [COORD_W-1:0] v0_z_i,
  input  logic signed [COORD_W-1:0] v1_x_i,
  input  logic signed [COORD_W-1:0] v1_y_i,
  input  logic signed [COORD_W-1:0] v1_z_i,
  input  logic signed [COORD_W-1:0] v2_x_i,
  input  logic signed [COORD_W-1:0] v2_y_i,
  input  logic signed [COORD_W-1:0] v2_z_i,
  input  logic signed [COORD_W-1:0] v3_x_i,
  input  logic signed [COORD_W-1:0] v3_y_i,
  input  logic signed [COORD_W-1:0] v3_z_i,
  output logic                      out_valid_o,
  input  logic                      out_stall_i,
  output logic [1:0]                node_index_o,
  output logic signed [DER_W-1:0]   dhdx_x_o,
  output logic signed [DER_W-1:0]   dhdx_y_o,
  output logic signed [DER_W-1:0]   dhdx_z_o,
  output logic [VOL_W-1:0]          volume_o,
  output logic                      singular_o,
  output logic                      last_o
);

  logic signed [COORD_W-1:0] vin [4][3];

  logic en, fe_en;
  logic [7:1] fv_q;

  logic signed [DIFF_W-1:0] jac1_q [3][3];
  logic signed [PROD_W-1:0] pa2_q [3][3];
  logic signed [PROD_W-1:0] pb2_q [3][3];
  logic signed [DIFF_W-1:0] j02_q [3];
  logic signed [DIFF_W-1:0] j03_q [3];
  logic signed [ADJ_W-1:0]  adj3_q [3][3];
  logic signed [ADJ_W-1:0]  adj4_q [3][3];
  logic signed [ADJ_W-1:0]  adj5_q [3][3];
  logic signed [ADJ_W-1:0]  adj6_q [3][3];
  logic signed [ADJ_W-1:0]  adj7_q [3][3];
  logic signed [ADJ_W-1:0]  el_adj_q [3][3];
  logic signed [SUM_W-1:0]  sum4_q [3];
  logic signed [SUM_W-1:0]  sum5_q [3];
  logic signed [SUM_W-1:0]  sum6_q [3];
  logic signed [SUM_W-1:0]  sum7_q [3];
  logic signed [SUM_W-1:0]  el_sum_q [3];
  logic signed [PL_W-1:0]   pl4_q [3];
  logic signed [PH_W-1:0]   ph4_q [3];
  logic signed [DET_W-1:0]  dm5_q [3];
  logic signed [DET_W-1:0]  det6_q;
  logic [MAG_W-1:0]         dmag7_q, el_dmag_q;
  logic                     dneg7_q, sing7_q, el_dneg_q, el_sing_q;
  logic [VOL_NUM_W-1:0]     el_vy_q;
  logic                     el_vsat_q, el_v_q;
  logic [1:0]               cnt_q;
  logic [MAG_W:0]           ysum, yval;

  logic                     nv_q, nd_q;
  beat_t                    nb_q;
  logic signed [SUM_W-1:0]  nt_q [3];

  beat_t                    bq [DIV_STEPS+1];
  lane_t                    lq [DIV_STEPS+1][3];
  logic [DIV_STEPS:0]       sv_q;

  logic                     out_valid_q, sing_q, last_q;
  logic [1:0]               node_q;
  logic [DER_W-1:0]         der_q [3];
  logic [VOL_W-1:0]         vol_q;

  assign vin[0][0] = v0_x_i;  assign vin[0][1] = v0_y_i;  assign vin[0][2] = v0_z_i;
  assign vin[1][0] = v1_x_i;  assign vin[1][1] = v1_y_i;  assign vin[1][2] = v1_z_i;
  assign vin[2][0] = v2_x_i;  assign vin[2][1] = v2_y_i;  assign vin[2][2] = v2_z_i;
  assign vin[3][0] = v3_x_i;  assign vin[3][1] = v3_y_i;  assign vin[3][2] = v3_z_i;

  assign en         = !out_valid_q || !out_stall_i;
  assign fe_en      = en && (!el_v_q || cnt_q == LAST_NODE);
  assign in_stall_o = !fe_en;

  // element front end
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fv_q <= '0;
    end else if (fe_en) begin
      fv_q <= {fv_q[6:1], in_valid_i};
    end
  end

  always_ff @(posedge clk_i) begin
    if (fe_en) begin
      for (int r = 0; r < 3; r++) begin
        for (int c = 0; c < 3; c++) begin
          jac1_q[r][c] <= DIFF_W'(vin[r+1][c]) - DIFF_W'(vin[0][c]);
        end
      end
      for (int k = 0; k < 3; k++) begin
        for (int m = 0; m < 3; m++) begin
          pa2_q[k][m] <= jac1_q[(m+1)%3][(k+1)%3] * jac1_q[(m+2)%3][(k+2)%3];
          pb2_q[k][m] <= jac1_q[(m+1)%3][(k+2)%3] * jac1_q[(m+2)%3][(k+1)%3];
          adj3_q[k][m] <= ADJ_W'(pa2_q[k][m]) - ADJ_W'(pb2_q[k][m]);
        end
      end
      j02_q <= jac1_q[0];
      j03_q <= j02_q;
      for (int m = 0; m < 3; m++) begin
        pl4_q[m] <= j03_q[m] * $signed({1'b0, adj3_q[m][0][ADJ_LO_W-1:0]});
        ph4_q[m] <= j03_q[m] * $signed(adj3_q[m][0][ADJ_W-1:ADJ_LO_W]);
        sum4_q[m] <= SUM_W'(adj3_q[m][0]) + SUM_W'(adj3_q[m][1]) + SUM_W'(adj3_q[m][2]);
        dm5_q[m] <= (DET_W'(ph4_q[m]) <<< ADJ_LO_W) + DET_W'(pl4_q[m]);
      end
      adj4_q <= adj3_q;
      adj5_q <= adj4_q;
      adj6_q <= adj5_q;
      adj7_q <= adj6_q;
      sum5_q <= sum4_q;
      sum6_q <= sum5_q;
      sum7_q <= sum6_q;
      det6_q <= dm5_q[0] + dm5_q[1] + dm5_q[2];
      dmag7_q <= det6_q[DET_W-1] ? MAG_W'(-det6_q) : MAG_W'(det6_q);
      dneg7_q <= det6_q[DET_W-1];
      sing7_q <= (det6_q == '0);
    end
  end

  // element hold and node serializer
  assign ysum = (MAG_W + 1)'(dmag7_q) + VOL_BIAS;
  assign yval = ysum >> VOL_SHIFT;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      el_v_q <= 1'b0;
      cnt_q  <= '0;
      nv_q   <= 1'b0;
    end else if (en) begin
      nv_q <= el_v_q;
      if (fe_en) begin
        el_v_q <= fv_q[7];
        cnt_q  <= '0;
      end else begin
        cnt_q <= cnt_q + 2'd1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (fe_en) begin
      el_adj_q  <= adj7_q;
      el_sum_q  <= sum7_q;
      el_dmag_q <= dmag7_q;
      el_dneg_q <= dneg7_q;
      el_sing_q <= sing7_q;
      el_vy_q   <= VOL_NUM_W'(yval);
      el_vsat_q <= (yval >= VOL_SAT_Y);
    end
    if (en) begin
      nb_q.dmag <= el_dmag_q;
      nb_q.sing <= el_sing_q;
      nb_q.node <= cnt_q;
      nb_q.last <= (cnt_q == LAST_NODE);
      nb_q.vw   <= el_vy_q;
      nb_q.vr   <= '0;
      nb_q.vsat <= el_vsat_q;
      nd_q      <= el_dneg_q;
      for (int k = 0; k < 3; k++) begin
        case (cnt_q)
          2'd0:    nt_q[k] <= -el_sum_q[k];
          2'd1:    nt_q[k] <= SUM_W'(el_adj_q[k][0]);
          2'd2:    nt_q[k] <= SUM_W'(el_adj_q[k][1]);
          default: nt_q[k] <= SUM_W'(el_adj_q[k][2]);
        endcase
      end
    end
  end

  // divider setup: magnitude, quotient sign, overflow check
  always_ff @(posedge clk_i) begin
    if (en) begin
      bq[0] <= nb_q;
      for (int k = 0; k < 3; k++) begin
        lq[0][k].rem <= MAG_W'(nt_q[k][SUM_W-1] ? -nt_q[k] : nt_q[k]);
        lq[0][k].quo <= '0;
        lq[0][k].neg <= nt_q[k][SUM_W-1] ^ nd_q;
        lq[0][k].ovf <= MAG_W'(nt_q[k][SUM_W-1] ? -nt_q[k] : nt_q[k]) >= nb_q.dmag;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sv_q <= '0;
    end else if (en) begin
      sv_q <= {sv_q[DIV_STEPS-1:0], nv_q};
    end
  end

  // one quotient bit per lane and two volume digits per stage
  for (genvar s = 0; s < DIV_STEPS; s++) begin : g_step
    beat_t b_d;
    lane_t l_d [3];

    always_comb begin
      logic [MAG_W:0]       rem2;
      logic [2:0]           vrr;
      logic [VOL_NUM_W-1:0] vw;
      logic [1:0]           vr;
      b_d = bq[s];
      vw  = bq[s].vw;
      vr  = bq[s].vr;
      for (int i = 0; i < 2; i++) begin
        vrr = {vr, vw[VOL_NUM_W-1]};
        vw  = {vw[VOL_NUM_W-2:0], vrr >= 3'd3};
        vr  = (vrr >= 3'd3) ? 2'(vrr - 3'd3) : vrr[1:0];
      end
      b_d.vw = vw;
      b_d.vr = vr;
      for (int k = 0; k < 3; k++) begin
        l_d[k] = lq[s][k];
        rem2   = {lq[s][k].rem, 1'b0};
        if (rem2 >= {1'b0, bq[s].dmag}) begin
          l_d[k].rem = MAG_W'(rem2 - {1'b0, bq[s].dmag});
          l_d[k].quo = {lq[s][k].quo[DIV_STEPS-2:0], 1'b1};
        end else begin
          l_d[k].rem = MAG_W'(rem2);
          l_d[k].quo = {lq[s][k].quo[DIV_STEPS-2:0], 1'b0};
        end
      end
    end

    always_ff @(posedge clk_i) begin
      if (en) begin
        bq[s+1] <= b_d;
        lq[s+1] <= l_d;
      end
    end
  end

  // round, saturate and drive the result beat
  function automatic logic [DER_W-1:0] der_out(lane_t l, logic sing);
    logic [DER_W:0] qr;
    logic           sat;
    qr  = {1'b0, l.quo[DIV_STEPS-1:1]} + (DER_W + 1)'(l.quo[0]);
    sat = l.ovf || (qr[DER_W:DER_W-1] != 2'b00);
    if (sing) begin
      return '0;
    end
    if (sat) begin
      return l.neg ? DER_MIN : DER_MAX;
    end
    return l.neg ? DER_W'(-qr[DER_W-1:0]) : qr[DER_W-1:0];
  endfunction

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (en) begin
      out_valid_q <= sv_q[DIV_STEPS];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      node_q <= bq[DIV_STEPS].node;
      sing_q <= bq[DIV_STEPS].sing;
      last_q <= bq[DIV_STEPS].last;
      for (int k = 0; k < 3; k++) begin
        der_q[k] <= der_out(lq[DIV_STEPS][k], bq[DIV_STEPS].sing);
      end
      if (bq[DIV_STEPS].sing) begin
        vol_q <= '0;
      end else if (bq[DIV_STEPS].vsat) begin
        vol_q <= VOL_MAX;
      end else begin
        vol_q <= bq[DIV_STEPS].vw[VOL_W-1:0];
      end
    end
  end

  assign out_valid_o  = out_valid_q;
  assign node_index_o = node_q;
  assign dhdx_x_o     = der_q[0];
  assign dhdx_y_o     = der_q[1];
  assign dhdx_z_o     = der_q[2];
  assign volume_o     = vol_q;
  assign singular_o   = sing_q;
  assign last_o       = last_q;

endmodule
